// ===== rtl/core/hcl_pkg.sv =====
// Shared types and constants for the Huffman code length core.
// Used by hcl_alu, huffman_code_length_calc_core and hcl_checker; no dependencies.
package hcl_pkg;

  localparam int unsigned MAX_SYMBOLS = 256;
  localparam int unsigned WEIGHT_BITS = 24;
  localparam int unsigned NODE_W      = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_SYMBOLS);
  localparam int unsigned CNT_W       = IDX_W + 1;
  localparam int unsigned POS_W       = 8;
  localparam int unsigned LEN_W       = 8;

  typedef enum logic {
    CMD_LOAD = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ALU_ADD_SAT,
    ALU_INC,
    ALU_LT,
    ALU_EQ
  } alu_op_e;

  typedef struct packed {
    logic [NODE_W-1:0] value;
    logic              flag;
  } alu_res_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_M_RD_LEAF,
    ST_M_RD_ROOT,
    ST_M_PICK,
    ST_M_WR_SUM,
    ST_D_INIT,
    ST_D_RD,
    ST_D_PTR,
    ST_D_WR,
    ST_L_INIT,
    ST_L_RD,
    ST_L_CMP,
    ST_L_FILL
  } state_e;

endpackage

// ===== rtl/core/huffman_code_length_calc_core.sv =====
// Top level of the in-place Huffman code length core: node store, sequencer, I/O.
// Depends on hcl_pkg and hcl_alu.
//
//   channel   | handshake                    | payload
//   ----------+------------------------------+------------------------------------------
//   config    | symbol_count_we_i            | symbol_count_i
//   command   | start_i & !busy_o            | command_i, position_i, weight_i, last_load_i
//   result    | done_o (one-cycle strobe)    | code_length_o, read_position_o, not_ready_o
//
// A load or read item is taken when start_i is high and busy_o is low; a read's result
// strobes on the next cycle, and reads may be issued back to back. A load with last_load_i
// runs the three passes (merge, depths, lengths), all through the single read port of the
// node store and one shared ALU. busy_o is high meanwhile. Reset is asynchronous, active
// low; the store itself is not cleared. Results cannot stall.
module huffman_code_length_calc_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          symbol_count_we_i,
  input  logic [hcl_pkg::CNT_W-1:0]     symbol_count_i,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic                          command_i,
  input  logic [hcl_pkg::POS_W-1:0]     position_i,
  input  logic [hcl_pkg::WEIGHT_BITS-1:0] weight_i,
  input  logic                          last_load_i,
  output logic                          done_o,
  output logic [hcl_pkg::LEN_W-1:0]     code_length_o,
  output logic [hcl_pkg::POS_W-1:0]     read_position_o,
  output logic                          not_ready_o
);
  import hcl_pkg::*;

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  symbol_count_q;
  logic [CNT_W-1:0]  n_cnt;
  logic [CNT_W-1:0]  leaf_q, leaf_d;
  logic [CNT_W-1:0]  root_q, root_d;
  logic [CNT_W-1:0]  next_q, next_d;
  logic [CNT_W-1:0]  avail_q, avail_d;
  logic [CNT_W-1:0]  used_q, used_d;
  logic [CNT_W-1:0]  depth_q, depth_d;
  logic              second_q, second_d;
  logic              results_ok_q, results_ok_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_nr_q, rsp_nr_d;
  logic [POS_W-1:0]  rsp_pos_q, rsp_pos_d;
  logic [NODE_W-1:0] first_q, first_d;
  logic [NODE_W-1:0] take_q, take_d;
  logic [NODE_W-1:0] leaf_w_q, leaf_w_d;

  logic [NODE_W-1:0] node_mem [MAX_SYMBOLS];
  logic [NODE_W-1:0] rd_data_q;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [NODE_W-1:0] wr_data;
  logic              wr_en;

  alu_op_e           alu_op;
  logic [NODE_W-1:0] alu_a, alu_b;
  alu_res_t          alu_res;

  logic              accept;
  logic              take_root;
  logic              fill_more;
  logic [NODE_W-1:0] pick_w;

  hcl_alu u_alu (
    .op_i  (alu_op),
    .a_i   (alu_a),
    .b_i   (alu_b),
    .res_o (alu_res)
  );

  // symbol count saturated into 2..MAX_SYMBOLS
  always_comb begin
    if (symbol_count_q < CNT_W'(2)) begin
      n_cnt = CNT_W'(2);
    end else if (symbol_count_q > CNT_W'(MAX_SYMBOLS)) begin
      n_cnt = CNT_W'(MAX_SYMBOLS);
    end else begin
      n_cnt = symbol_count_q;
    end
  end

  assign busy_o    = (state_q != ST_IDLE);
  assign accept    = start_i && !busy_o;
  // root wins when leaves are exhausted or a strictly lighter root is pending
  assign take_root = (leaf_q >= n_cnt) || ((root_q < next_q) && alu_res.flag);
  assign pick_w    = take_root ? rd_data_q : leaf_w_q;
  // msb of next marks it gone below zero
  assign fill_more = (avail_q > used_q) && !next_q[CNT_W-1];

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept && (command_i == CMD_LOAD) && last_load_i) state_d = ST_M_RD_LEAF;
      end
      ST_M_RD_LEAF: state_d = ST_M_RD_ROOT;
      ST_M_RD_ROOT: state_d = ST_M_PICK;
      ST_M_PICK: begin
        state_d = second_q ? ST_M_WR_SUM : ST_M_RD_LEAF;
      end
      ST_M_WR_SUM: begin
        state_d = (next_q == n_cnt - CNT_W'(2)) ? ST_D_INIT : ST_M_RD_LEAF;
      end
      ST_D_INIT: begin
        state_d = (n_cnt == CNT_W'(2)) ? ST_L_INIT : ST_D_RD;
      end
      ST_D_RD:  state_d = ST_D_PTR;
      ST_D_PTR: state_d = ST_D_WR;
      ST_D_WR: begin
        state_d = (next_q == '0) ? ST_L_INIT : ST_D_RD;
      end
      ST_L_INIT: state_d = ST_L_RD;
      ST_L_RD:   state_d = ST_L_CMP;
      ST_L_CMP: begin
        if (alu_res.flag && (root_q != '0)) begin
          state_d = ST_L_RD;
        end else begin
          state_d = ST_L_FILL;
        end
      end
      ST_L_FILL: begin
        if (!fill_more) begin
          if ((depth_q >= n_cnt) || (used_q == '0)) begin
            state_d = ST_IDLE;
          end else if (root_q[CNT_W-1]) begin
            state_d = ST_L_FILL;
          end else begin
            state_d = ST_L_RD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and store control
  always_comb begin
    leaf_d       = leaf_q;
    root_d       = root_q;
    next_d       = next_q;
    avail_d      = avail_q;
    used_d       = used_q;
    depth_d      = depth_q;
    second_d     = second_q;
    results_ok_d = results_ok_q;
    rsp_valid_d  = 1'b0;
    rsp_nr_d     = rsp_nr_q;
    rsp_pos_d    = rsp_pos_q;
    first_d      = first_q;
    take_d       = take_q;
    leaf_w_d     = leaf_w_q;
    rd_addr      = position_i;
    wr_en        = 1'b0;
    wr_addr      = position_i;
    wr_data      = NODE_W'(weight_i);
    alu_op       = ALU_EQ;
    alu_a        = rd_data_q;
    alu_b        = leaf_w_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (command_i == CMD_LOAD) begin
            wr_en        = 1'b1;
            results_ok_d = 1'b0;
            leaf_d       = '0;
            root_d       = '0;
            next_d       = '0;
            second_d     = 1'b0;
          end else begin
            rsp_valid_d = 1'b1;
            rsp_pos_d   = position_i;
            rsp_nr_d    = !(results_ok_q && (CNT_W'(position_i) < n_cnt));
          end
        end
      end
      ST_M_RD_LEAF: begin
        rd_addr = leaf_q[IDX_W-1:0];
      end
      ST_M_RD_ROOT: begin
        rd_addr  = root_q[IDX_W-1:0];
        leaf_w_d = rd_data_q;
      end
      ST_M_PICK: begin
        alu_op = ALU_LT;
        if (take_root) begin
          wr_en   = 1'b1;
          wr_addr = root_q[IDX_W-1:0];
          wr_data = NODE_W'(next_q);
          root_d  = root_q + CNT_W'(1);
        end else begin
          leaf_d = leaf_q + CNT_W'(1);
        end
        if (second_q) begin
          take_d = pick_w;
        end else begin
          first_d  = pick_w;
          second_d = 1'b1;
        end
      end
      ST_M_WR_SUM: begin
        alu_op   = ALU_ADD_SAT;
        alu_a    = first_q;
        alu_b    = take_q;
        wr_en    = 1'b1;
        wr_addr  = next_q[IDX_W-1:0];
        wr_data  = alu_res.value;
        second_d = 1'b0;
        next_d   = (next_q == n_cnt - CNT_W'(2)) ? next_q : next_q + CNT_W'(1);
      end
      ST_D_INIT: begin
        // the root sits at depth zero
        wr_en   = 1'b1;
        wr_addr = IDX_W'(n_cnt - CNT_W'(2));
        wr_data = '0;
        next_d  = n_cnt - CNT_W'(3);
      end
      ST_D_RD: begin
        rd_addr = next_q[IDX_W-1:0];
      end
      ST_D_PTR: begin
        // out-of-range parent pointers fall back to the root
        alu_op  = ALU_LT;
        alu_b   = NODE_W'(n_cnt);
        rd_addr = alu_res.flag ? rd_data_q[IDX_W-1:0] : IDX_W'(n_cnt - CNT_W'(2));
      end
      ST_D_WR: begin
        alu_op  = ALU_INC;
        wr_en   = 1'b1;
        wr_addr = next_q[IDX_W-1:0];
        wr_data = alu_res.value;
        if (next_q != '0) next_d = next_q - CNT_W'(1);
      end
      ST_L_INIT: begin
        avail_d = CNT_W'(1);
        used_d  = '0;
        depth_d = '0;
        root_d  = n_cnt - CNT_W'(2);
        next_d  = n_cnt - CNT_W'(1);
      end
      ST_L_RD: begin
        rd_addr = root_q[IDX_W-1:0];
      end
      ST_L_CMP: begin
        alu_op = ALU_EQ;
        alu_b  = NODE_W'(depth_q);
        if (alu_res.flag) begin
          used_d = used_q + CNT_W'(1);
          root_d = root_q - CNT_W'(1);
        end
      end
      ST_L_FILL: begin
        if (fill_more) begin
          wr_en   = 1'b1;
          wr_addr = next_q[IDX_W-1:0];
          wr_data = NODE_W'(depth_q);
          next_d  = next_q - CNT_W'(1);
          avail_d = avail_q - CNT_W'(1);
        end else begin
          avail_d = {used_q[CNT_W-2:0], 1'b0};
          depth_d = depth_q + CNT_W'(1);
          used_d  = '0;
          if ((depth_q >= n_cnt) || (used_q == '0)) results_ok_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_IDLE;
      symbol_count_q <= CNT_W'(MAX_SYMBOLS);
      leaf_q         <= '0;
      root_q         <= '0;
      next_q         <= '0;
      avail_q        <= '0;
      used_q         <= '0;
      depth_q        <= '0;
      second_q       <= 1'b0;
      results_ok_q   <= 1'b0;
      rsp_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      if (symbol_count_we_i) symbol_count_q <= symbol_count_i;
      leaf_q         <= leaf_d;
      root_q         <= root_d;
      next_q         <= next_d;
      avail_q        <= avail_d;
      used_q         <= used_d;
      depth_q        <= depth_d;
      second_q       <= second_d;
      results_ok_q   <= results_ok_d;
      rsp_valid_q    <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rsp_nr_q  <= rsp_nr_d;
    rsp_pos_q <= rsp_pos_d;
    first_q   <= first_d;
    take_q    <= take_d;
    leaf_w_q  <= leaf_w_d;
  end

  // node store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_en) node_mem[wr_addr] <= wr_data;
    rd_data_q <= node_mem[rd_addr];
  end

  assign done_o          = rsp_valid_q;
  assign read_position_o = rsp_pos_q;
  assign not_ready_o     = rsp_nr_q;
  assign code_length_o   = rsp_nr_q ? '0 : rd_data_q[LEN_W-1:0];

endmodule

// ===== rtl/core/hcl_alu.sv =====
// Shared arithmetic unit: saturating add, increment, less-than and equality.
// Depends on hcl_pkg.
module hcl_alu (
  input  hcl_pkg::alu_op_e             op_i,
  input  logic [hcl_pkg::NODE_W-1:0]   a_i,
  input  logic [hcl_pkg::NODE_W-1:0]   b_i,
  output hcl_pkg::alu_res_t            res_o
);
  import hcl_pkg::*;

  logic [NODE_W-1:0] addend;
  logic [NODE_W:0]   sum;

  always_comb begin
    addend          = (op_i == ALU_INC) ? NODE_W'(1) : b_i;
    sum             = {1'b0, a_i} + {1'b0, addend};
    res_o.value     = sum[NODE_W-1:0];
    res_o.flag      = 1'b0;
    unique case (op_i)
      ALU_ADD_SAT: begin
        if (sum[NODE_W]) res_o.value = '1;
        res_o.flag = sum[NODE_W];
      end
      ALU_INC: begin
        res_o.flag = sum[NODE_W];
      end
      ALU_LT: begin
        res_o.flag = (a_i < b_i);
      end
      ALU_EQ: begin
        res_o.flag = (a_i == b_i);
      end
    endcase
  end

endmodule

// ===== rtl/core/hcl_checker.sv =====
// Port-level checks for huffman_code_length_calc_core, attached by bind.
// Depends on hcl_pkg.
module hcl_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      start_i,
  input logic                      busy_o,
  input logic                      command_i,
  input logic [hcl_pkg::POS_W-1:0] position_i,
  input logic                      last_load_i,
  input logic                      done_o,
  input logic [hcl_pkg::POS_W-1:0] read_position_o,
  input logic                      not_ready_o
);
  import hcl_pkg::*;

  logic rd_acc;
  logic ld_acc;

  assign rd_acc = start_i && !busy_o && (command_i == CMD_READ);
  assign ld_acc = start_i && !busy_o && (command_i == CMD_LOAD);

  // every read item gets its result on the next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_acc |=> done_o)
    else $error("read item without result strobe");

  // no result without a read item in the cycle before
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(rd_acc))
    else $error("result strobe without read item");

  a_pos_echo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (read_position_o == $past(position_i)))
    else $error("read position echo mismatch");

  // last load starts the computation
  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_acc && last_load_i) |=> busy_o)
    else $error("last load did not start computation");

  // a plain load invalidates earlier lengths
  a_load_invalidates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ld_acc && !last_load_i) ##1 rd_acc |=> not_ready_o)
    else $error("read after load not flagged");

endmodule

bind huffman_code_length_calc_core hcl_checker u_hcl_checker (.*);
